FILE: rtl/core/admx_pkg.sv
// Package for the downmix / resampler core: widths, constants, codes and shared types.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package admx_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_CHANNELS    = 8;
  localparam int PCM_BITS        = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DIV_RADIX_BITS  = 4;

  localparam int CC_W      = 4;
  localparam int STEP_W    = 20;
  localparam int FRAC_W    = 16;
  localparam int POS_W     = 21;
  localparam int MAG_W     = 21;
  localparam int SCALE_W   = 15;
  localparam int CFG_IDX_W = 1;

  localparam logic [CC_W-1:0]    CHAN_RESET  = CC_W'(1);
  localparam logic [CC_W-1:0]    CHAN_MAX    = CC_W'(MAX_CHANNELS);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);
  localparam logic [STEP_W-1:0]  STEP_MIN    = STEP_W'(16384);
  localparam logic [POS_W-1:0]   POS_ONE     = POS_W'(65536);
  localparam logic [MAG_W-1:0]   ONE_Q20     = MAG_W'(1048576);
  localparam logic [SCALE_W-1:0] PCM_POS_SCALE = SCALE_W'(32767);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_RESAMPLE_STEP = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_INTERP,
    SQ_REPEAT
  } seq_state_t;

  // Control that travels with each result slot down the back-end pipeline.
  typedef struct packed {
    logic valid;
    logic run_end;
    logic stream_end;
  } slot_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/admx_if.sv
// Request channels of the downmix / resampler core: multichannel frames in, PCM samples out.
// Depends on admx_pkg for default widths.
`default_nettype none

interface admx_in_if #(
  parameter int SAMPLE_BITS = admx_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] chan0;
  logic signed [SAMPLE_BITS-1:0] chan1;
  logic signed [SAMPLE_BITS-1:0] chan2;
  logic signed [SAMPLE_BITS-1:0] chan3;
  logic signed [SAMPLE_BITS-1:0] chan4;
  logic signed [SAMPLE_BITS-1:0] chan5;
  logic signed [SAMPLE_BITS-1:0] chan6;
  logic signed [SAMPLE_BITS-1:0] chan7;
  logic                          final_frame;

  modport source (
    output valid, chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7, final_frame,
    input  ready
  );
  modport sink (
    input  valid, chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7, final_frame,
    output ready
  );
endinterface

interface admx_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [admx_pkg::PCM_BITS-1:0] pcm_sample;
  logic                                run_end;
  logic                                stream_end;

  modport source (output valid, pcm_sample, run_end, stream_end, input ready);
  modport sink   (input  valid, pcm_sample, run_end, stream_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/admx_front.sv
// Front end: takes a frame request, sums the active channels and divides by the channel count.
// Depends on admx_pkg and admx_in_if; hands the mono sample to the queue.
`default_nettype none

module admx_front #(
  parameter int SAMPLE_BITS = admx_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  admx_in_if.sink                           in_ch,
  input  wire logic [admx_pkg::CC_W-1:0]    chans,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output logic signed [SAMPLE_BITS-1:0]     push_mono,
  output logic                              push_final
);
  import admx_pkg::*;

  localparam int SUM_W     = SAMPLE_BITS + 3;
  localparam int DIV_STEPS = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int PAD_W     = DIV_STEPS * DIV_RADIX_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  front_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] chan_w [MAX_CHANNELS];
  logic signed [SUM_W-1:0]       sum_w;
  logic [SUM_W-1:0]              mag_w;
  logic                          in_fire;

  logic [PAD_W-1:0]  work_r, work_nxt;
  logic [CC_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic              final_r;
  logic [SUM_W-1:0]  quot_w;

  assign chan_w[0] = in_ch.chan0;
  assign chan_w[1] = in_ch.chan1;
  assign chan_w[2] = in_ch.chan2;
  assign chan_w[3] = in_ch.chan3;
  assign chan_w[4] = in_ch.chan4;
  assign chan_w[5] = in_ch.chan5;
  assign chan_w[6] = in_ch.chan6;
  assign chan_w[7] = in_ch.chan7;

  always_comb begin
    sum_w = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (CC_W'(c) < chans) begin
        sum_w = sum_w + SUM_W'(chan_w[c]);
      end
    end
  end

  assign mag_w   = sum_w[SUM_W-1] ? SUM_W'(-sum_w) : SUM_W'(sum_w);
  assign in_fire = in_ch.valid && in_ch.ready;

  // Restoring division, four quotient bits per cycle; the remainder stays below the divisor.
  always_comb begin
    logic [CC_W:0] trial;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    for (int b = 0; b < DIV_RADIX_BITS; b++) begin
      trial = {rem_nxt, work_nxt[PAD_W-1]};
      if (trial >= {1'b0, chans}) begin
        trial = trial - {1'b0, chans};
        work_nxt = {work_nxt[PAD_W-2:0], 1'b1};
      end else begin
        work_nxt = {work_nxt[PAD_W-2:0], 1'b0};
      end
      rem_nxt = trial[CC_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (in_fire) state_nxt = FS_DIV;
      FS_DIV:  if (cnt_r == '0) state_nxt = FS_PUSH;
      FS_PUSH: if (push_ready) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    unique case (state_r)
      FS_IDLE: in_ch.ready = 1'b1;
      FS_DIV:  ;
      FS_PUSH: push_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      work_r  <= PAD_W'(mag_w);
      rem_r   <= '0;
      cnt_r   <= CNT_W'(DIV_STEPS - 1);
      neg_r   <= sum_w[SUM_W-1];
      final_r <= in_ch.final_frame;
    end else if (state_r == FS_DIV) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  assign quot_w     = work_r[SUM_W-1:0];
  assign push_mono  = neg_r ? SAMPLE_BITS'(-quot_w) : SAMPLE_BITS'(quot_w);
  assign push_final = final_r;

endmodule

`default_nettype wire

FILE: rtl/core/admx_fifo.sv
// Short register queue between the front end and the back end.
// Generic width and depth; no package dependency beyond defaults.
`default_nettype none

module admx_fifo #(
  parameter int WIDTH = 25,
  parameter int DEPTH = admx_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/admx_seq.sv
// Back-end sequencer: walks the output positions of each mono sample and issues result slots.
// Depends on admx_pkg; feeds admx_pipe.
`default_nettype none

module admx_seq #(
  parameter int SAMPLE_BITS = admx_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [admx_pkg::STEP_W-1:0]    step,
  input  wire logic                           pop_valid,
  output logic                                pop_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]  pop_mono,
  input  wire logic                           pop_final,
  input  wire logic                           adv,
  output admx_pkg::slot_flags_t               issue,
  output logic signed [SAMPLE_BITS-1:0]       issue_base,
  output logic signed [SAMPLE_BITS:0]         issue_diff,
  output logic [admx_pkg::FRAC_W-1:0]         issue_frac
);
  import admx_pkg::*;

  seq_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic                          have_r, have_nxt;
  logic                          fin_r, fin_nxt;

  logic [POS_W-1:0] pos_sum, pos_wrap, held_wrap;
  logic             sum_past, wrap_past, held_past, held_wrap_past;
  logic             pop_fire;

  assign pos_sum        = pos_r + POS_W'(step);
  assign pos_wrap       = pos_sum - POS_ONE;
  assign held_wrap      = pos_r - POS_ONE;
  assign sum_past       = |pos_sum[POS_W-1:FRAC_W];
  assign wrap_past      = |pos_wrap[POS_W-1:FRAC_W];
  assign held_past      = |pos_r[POS_W-1:FRAC_W];
  assign held_wrap_past = |held_wrap[POS_W-1:FRAC_W];
  assign pop_ready      = (state_r == SQ_IDLE);
  assign pop_fire       = pop_valid && pop_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (pop_fire) begin
          if (!have_r) begin
            state_nxt = pop_final ? SQ_REPEAT : SQ_IDLE;
          end else if (!held_past) begin
            state_nxt = SQ_INTERP;
          end else if (pop_final && !held_wrap_past) begin
            state_nxt = SQ_REPEAT;
          end
        end
      end
      SQ_INTERP: begin
        if (adv && sum_past) begin
          state_nxt = (fin_r && !wrap_past) ? SQ_REPEAT : SQ_IDLE;
        end
      end
      SQ_REPEAT: if (adv && sum_past) state_nxt = SQ_IDLE;
      default:   state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    issue      = '0;
    issue_base = prev_r;
    issue_diff = '0;
    issue_frac = '0;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    have_nxt   = have_r;
    fin_nxt    = fin_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (pop_fire) begin
          cur_nxt = pop_mono;
          fin_nxt = pop_final;
          if (!have_r) begin
            // First sample of a stream is only held.
            have_nxt = 1'b1;
            prev_nxt = pop_mono;
            pos_nxt  = '0;
          end else if (held_past) begin
            // No position falls before this sample.
            prev_nxt = pop_mono;
            if (pop_final && held_wrap_past) begin
              prev_nxt = '0;
              pos_nxt  = '0;
              have_nxt = 1'b0;
            end else begin
              pos_nxt = held_wrap;
            end
          end
        end
      end
      SQ_INTERP: begin
        issue.valid = 1'b1;
        issue_base  = prev_r;
        issue_diff  = (SAMPLE_BITS+1)'(cur_r) - (SAMPLE_BITS+1)'(prev_r);
        issue_frac  = pos_r[FRAC_W-1:0];
        if (sum_past && !(fin_r && !wrap_past)) begin
          issue.run_end    = 1'b1;
          issue.stream_end = fin_r;
        end
        if (adv) begin
          if (!sum_past) begin
            pos_nxt = pos_sum;
          end else if (fin_r && wrap_past) begin
            prev_nxt = '0;
            pos_nxt  = '0;
            have_nxt = 1'b0;
          end else begin
            prev_nxt = cur_r;
            pos_nxt  = pos_wrap;
          end
        end
      end
      SQ_REPEAT: begin
        issue.valid      = 1'b1;
        issue_base       = cur_r;
        issue.run_end    = sum_past;
        issue.stream_end = sum_past;
        if (adv) begin
          if (sum_past) begin
            prev_nxt = '0;
            pos_nxt  = '0;
            have_nxt = 1'b0;
          end else begin
            pos_nxt = pos_sum;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      prev_r  <= '0;
      pos_r   <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      pos_r   <= pos_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    fin_r <= fin_nxt;
  end

`ifndef SYNTHESIS
  a_stream_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid && issue.stream_end |-> issue.run_end)
    else $error("stream end issued without run end");

  a_stream_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && issue.valid && issue.stream_end |=> !have_r && state_r == SQ_IDLE)
    else $error("stream state not cleared after its last result");

  a_first_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire && !have_r |=> have_r)
    else $error("first sample of a stream not held");

  a_no_issue_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SQ_IDLE |-> !issue.valid)
    else $error("result slot issued while idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/admx_pipe.sv
// Back-end datapath: interpolates, clamps and scales each issued slot to 16-bit PCM.
// Depends on admx_pkg and admx_out_if; the last stage is the output register.
`default_nettype none

module admx_pipe #(
  parameter int SAMPLE_BITS = admx_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire admx_pkg::slot_flags_t          issue,
  input  wire logic signed [SAMPLE_BITS-1:0]  issue_base,
  input  wire logic signed [SAMPLE_BITS:0]    issue_diff,
  input  wire logic [admx_pkg::FRAC_W-1:0]    issue_frac,
  output logic                                adv,
  admx_out_if.source                          out_ch
);
  import admx_pkg::*;

  localparam int P_W = SAMPLE_BITS + 1 + FRAC_W + 1;
  localparam int V_W = (SAMPLE_BITS + 2 > MAG_W + 1) ? SAMPLE_BITS + 2 : MAG_W + 1;
  localparam int PP_W = MAG_W + SCALE_W;

  slot_flags_t s1_f_r, s2_f_r, s3_f_r, s4_f_r;

  logic signed [SAMPLE_BITS-1:0] s1_base_r, s2_base_r;
  logic signed [SAMPLE_BITS:0]   s1_diff_r;
  logic [FRAC_W-1:0]             s1_frac_r;
  logic signed [P_W-1:0]         s2_prod_r;
  logic                          s3_neg_r, s4_neg_r;
  logic [MAG_W-1:0]              s3_mag_r;
  logic [PP_W-1:0]               s4_pprod_r;
  logic [PCM_BITS-1:0]           s4_nmag_r;

  logic                          out_valid_r, run_end_r, stream_end_r;
  logic signed [PCM_BITS-1:0]    pcm_r;

  logic signed [V_W-1:0]         v_w, clamp_w;
  logic signed [V_W-1:0]         one_v;

  assign adv   = !out_valid_r || out_ch.ready;
  assign one_v = V_W'(ONE_Q20);

  // prev*(1-f) + cur*f == prev + (cur-prev)*f, floored by the arithmetic shift.
  always_comb begin
    v_w = V_W'(s2_base_r) + V_W'(s2_prod_r >>> FRAC_W);
    if (v_w > one_v) begin
      clamp_w = one_v;
    end else if (v_w < -one_v) begin
      clamp_w = -one_v;
    end else begin
      clamp_w = v_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_f_r      <= '0;
      s2_f_r      <= '0;
      s3_f_r      <= '0;
      s4_f_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_f_r      <= issue;
      s2_f_r      <= s1_f_r;
      s3_f_r      <= s2_f_r;
      s4_f_r      <= s3_f_r;
      out_valid_r <= s4_f_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_base_r <= issue_base;
      s1_diff_r <= issue_diff;
      s1_frac_r <= issue_frac;

      s2_base_r <= s1_base_r;
      s2_prod_r <= s1_diff_r * $signed({1'b0, s1_frac_r});

      s3_neg_r  <= clamp_w[V_W-1];
      s3_mag_r  <= clamp_w[V_W-1] ? MAG_W'(-clamp_w) : MAG_W'(clamp_w);

      // Negatives scale by 32768 (a shift), positives by 32767.
      s4_neg_r   <= s3_neg_r;
      s4_nmag_r  <= s3_mag_r[MAG_W-1:MAG_W-PCM_BITS];
      s4_pprod_r <= s3_mag_r * PCM_POS_SCALE;

      pcm_r        <= s4_neg_r ? PCM_BITS'(-s4_nmag_r)
                               : s4_pprod_r[PP_W-1:PP_W-PCM_BITS];
      run_end_r    <= s4_f_r.run_end;
      stream_end_r <= s4_f_r.stream_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pcm_sample = pcm_r;
  assign out_ch.run_end    = run_end_r;
  assign out_ch.stream_end = stream_end_r;

endmodule

`default_nettype wire

FILE: rtl/core/audio_downmix_resample_pcm16_core.sv
// Each frame is taken while the front is idle, its active channels summed as it is taken, then
// divided in radix-16 steps of four quotient bits each and handed off once the queue has room.
// The front takes no new frame until then. A frame's PCM requests leave one per cycle while
// out_ch.ready is high; a frame yields 0 to 8 results, and a two-entry queue lets the front
// divide the next frame meanwhile. rst_n is synchronous, active low: it sets channel_count
// to 1 and resample_step to 65536 and drops the held sample and position.
`default_nettype none

module audio_downmix_resample_pcm16_core #(
  parameter int SAMPLE_BITS = admx_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  admx_in_if.sink                                in_ch,
  admx_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [admx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [admx_pkg::STEP_W-1:0]       cfg_wdata
);
  import admx_pkg::*;

  localparam int Q_W = SAMPLE_BITS + 1;

  // Configuration registers; the user writes them only while the block is idle; not enforced.
  logic [CC_W-1:0]   channel_count_r;
  logic [STEP_W-1:0] resample_step_r;

  // Register values as the datapath uses them: a zero count reads as one, counts above
  // the channel limit and steps below a quarter sample saturate.
  logic [CC_W-1:0]   chans_eff;
  logic [STEP_W-1:0] step_eff;

  // Front-to-queue and queue-to-sequencer requests.
  logic                          push_valid, push_ready, push_final;
  logic signed [SAMPLE_BITS-1:0] push_mono;
  logic                          pop_valid, pop_ready;
  logic [Q_W-1:0]                pop_data;

  // Sequencer-to-datapath result slots.
  slot_flags_t                   issue;
  logic signed [SAMPLE_BITS-1:0] issue_base;
  logic signed [SAMPLE_BITS:0]   issue_diff;
  logic [FRAC_W-1:0]             issue_frac;
  logic                          adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= CHAN_RESET;
      resample_step_r <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[CC_W-1:0];
        CFG_RESAMPLE_STEP: resample_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (channel_count_r == '0) begin
      chans_eff = CC_W'(1);
    end else if (channel_count_r > CHAN_MAX) begin
      chans_eff = CHAN_MAX;
    end else begin
      chans_eff = channel_count_r;
    end
    step_eff = (resample_step_r < STEP_MIN) ? STEP_MIN : resample_step_r;
  end

  // Front end: channel sum and iterative divide to one mono sample per frame.
  admx_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .chans      (chans_eff),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_mono  (push_mono),
    .push_final (push_final)
  );

  // Queue of mono samples, each with its end-of-stream mark.
  admx_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_final, push_mono}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: position stepping over the held and current sample.
  admx_seq #(.SAMPLE_BITS(SAMPLE_BITS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step_eff),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_mono   (pop_data[SAMPLE_BITS-1:0]),
    .pop_final  (pop_data[Q_W-1]),
    .adv        (adv),
    .issue      (issue),
    .issue_base (issue_base),
    .issue_diff (issue_diff),
    .issue_frac (issue_frac)
  );

  // Back end: interpolation, clamp and PCM scaling, ending in the output register.
  admx_pipe #(.SAMPLE_BITS(SAMPLE_BITS)) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_base (issue_base),
    .issue_diff (issue_diff),
    .issue_frac (issue_frac),
    .adv        (adv),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
